@@ src/rbs_pkg.sv @@
// ----------------------------------------------------------------------------
// rbs_pkg: shared types and constants for the ray/box slab test
// Fixed-point format, divider sizing, configuration indexes and the job
// record that travels from the front end to the back end.
// ----------------------------------------------------------------------------
`default_nettype none

package rbs_pkg;

  localparam int W         = 32;              // Q-format word width
  localparam int FRAC_BITS = 16;              // fraction bits (8..24)
  localparam int QB        = W + 1;           // quotient bits computed
  localparam int NW        = QB + FRAC_BITS;  // scaled dividend width
  localparam int CIW       = 3;               // config index width
  localparam int NSLAB     = 6;               // three axes, two corners each
  localparam int NAXIS     = 3;

  localparam logic [W-1:0] Q_MAX = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] Q_MIN = {1'b1, {(W-1){1'b0}}};

  typedef enum logic [CIW-1:0] {
    CFG_MIN_X = 3'd0,
    CFG_MIN_Y = 3'd1,
    CFG_MIN_Z = 3'd2,
    CFG_MAX_X = 3'd3,
    CFG_MAX_Y = 3'd4,
    CFG_MAX_Z = 3'd5
  } cfg_idx_e;

  // One slab parameter: |corner - origin| scaled, quotient sign, numerator sign
  typedef struct packed {
    logic [NW-1:0] num;
    logic          neg;
    logic          dpos;
  } slab_t;

  // One axis of the direction: magnitude and zero flag
  typedef struct packed {
    logic [W-1:0] dmag;
    logic         dz;
  } axis_t;

  typedef struct packed {
    slab_t [NSLAB-1:0] slab;
    axis_t [NAXIS-1:0] axis;
    logic  [W-1:0]     near_v;
    logic  [W-1:0]     far_v;
  } job_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

endpackage

`default_nettype wire

@@ src/rbs_front.sv @@
// ----------------------------------------------------------------------------
// rbs_front: box registers and ray classification
// Holds the box corners, forms the six slab numerators and the direction
// magnitudes, and pushes one job per accepted ray into the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module rbs_front (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      cfg_we_i,
  input  wire logic [rbs_pkg::CIW-1:0]   cfg_idx_i,
  input  wire logic [rbs_pkg::W-1:0]     cfg_wdata_i,
  input  wire logic                      in_valid_i,
  output      logic                      in_stall_o,
  input  wire logic [rbs_pkg::W-1:0]     origin_x_i,
  input  wire logic [rbs_pkg::W-1:0]     origin_y_i,
  input  wire logic [rbs_pkg::W-1:0]     origin_z_i,
  input  wire logic [rbs_pkg::W-1:0]     dir_x_i,
  input  wire logic [rbs_pkg::W-1:0]     dir_y_i,
  input  wire logic [rbs_pkg::W-1:0]     dir_z_i,
  input  wire logic [rbs_pkg::W-1:0]     near_in_i,
  input  wire logic [rbs_pkg::W-1:0]     far_in_i,
  input  wire rbs_pkg::q_status_t        q_st_i,
  output      logic                      push_o,
  output      rbs_pkg::job_t             job_o
);
  import rbs_pkg::*;

  logic [W-1:0] box_min_q [NAXIS];
  logic [W-1:0] box_max_q [NAXIS];
  logic [W-1:0] org       [NAXIS];
  logic [W-1:0] dir       [NAXIS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int a = 0; a < NAXIS; a++) begin
        box_min_q[a] <= '0;
        box_max_q[a] <= '0;
      end
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_MIN_X: box_min_q[0] <= cfg_wdata_i;
        CFG_MIN_Y: box_min_q[1] <= cfg_wdata_i;
        CFG_MIN_Z: box_min_q[2] <= cfg_wdata_i;
        CFG_MAX_X: box_max_q[0] <= cfg_wdata_i;
        CFG_MAX_Y: box_max_q[1] <= cfg_wdata_i;
        CFG_MAX_Z: box_max_q[2] <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign org[0] = origin_x_i;
  assign org[1] = origin_y_i;
  assign org[2] = origin_z_i;
  assign dir[0] = dir_x_i;
  assign dir[1] = dir_y_i;
  assign dir[2] = dir_z_i;

  always_comb begin
    logic [W-1:0] corner;
    logic [W:0]   diff;
    logic [W:0]   mag;
    job_o = '0;
    for (int a = 0; a < NAXIS; a++) begin
      job_o.axis[a].dz   = (dir[a] == '0);
      job_o.axis[a].dmag = dir[a][W-1] ? (~dir[a] + 1'b1) : dir[a];
      for (int s = 0; s < 2; s++) begin
        corner = (s == 0) ? box_min_q[a] : box_max_q[a];
        diff   = {corner[W-1], corner} - {org[a][W-1], org[a]};
        mag    = diff[W] ? (~diff + 1'b1) : diff;
        job_o.slab[a + NAXIS*s].num  = {mag, {FRAC_BITS{1'b0}}};
        job_o.slab[a + NAXIS*s].neg  = diff[W] ^ dir[a][W-1];
        job_o.slab[a + NAXIS*s].dpos = ~diff[W];
      end
    end
    job_o.near_v = near_in_i;
    job_o.far_v  = far_in_i;
  end

  assign in_stall_o = q_st_i.full;
  assign push_o     = in_valid_i && !q_st_i.full;

endmodule

`default_nettype wire

@@ src/rbs_queue.sv @@
// ----------------------------------------------------------------------------
// rbs_queue: two-entry job queue
// Decouples the front end from the divider pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module rbs_queue (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push_i,
  input  wire rbs_pkg::job_t      job_i,
  input  wire logic               pop_i,
  output      rbs_pkg::job_t      job_o,
  output      rbs_pkg::q_status_t st_o
);
  import rbs_pkg::*;

  job_t       mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (pop_i)  rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= job_i;
  end

  assign job_o    = mem_q[rd_ptr_q];
  assign st_o.empty = (cnt_q == 2'd0);
  assign st_o.full  = (cnt_q == 2'd2);

endmodule

`default_nettype wire

@@ src/rbs_div.sv @@
// ----------------------------------------------------------------------------
// rbs_div: pipelined slab divider
// Restoring division, one quotient bit per stage, with saturation to the
// signed word range and the zero-direction rule.
// ----------------------------------------------------------------------------
`default_nettype none

module rbs_div (
  input  wire logic                   clk_i,
  input  wire logic                   en_i,
  input  wire logic [rbs_pkg::NW-1:0] num_i,
  input  wire logic [rbs_pkg::W-1:0]  den_i,
  input  wire logic                   neg_i,
  input  wire logic                   dz_i,
  input  wire logic                   dpos_i,
  output      logic [rbs_pkg::W-1:0]  q_o
);
  import rbs_pkg::*;

  logic [W-1:0]  rem_q  [QB+1];
  logic [QB-1:0] low_q  [QB+1];
  logic [W-1:0]  den_q  [QB+1];
  logic          neg_q  [QB+1];
  logic          dz_q   [QB+1];
  logic          dpos_q [QB+1];
  logic          ovf_q  [QB+1];

  // Quotient of 2^QB or more always saturates
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]  <= W'(num_i[NW-1:QB]);
      low_q[0]  <= num_i[QB-1:0];
      den_q[0]  <= den_i;
      neg_q[0]  <= neg_i;
      dz_q[0]   <= dz_i;
      dpos_q[0] <= dpos_i;
      ovf_q[0]  <= (W'(num_i[NW-1:QB]) >= den_i);
    end
  end

  for (genvar s = 0; s < QB; s++) begin : g_step
    logic [W:0] r_ext;
    logic [W:0] trial;
    logic       qbit;
    assign r_ext = {rem_q[s], low_q[s][QB-1]};
    assign trial = r_ext - {1'b0, den_q[s]};
    assign qbit  = ~trial[W];
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s+1]  <= qbit ? trial[W-1:0] : r_ext[W-1:0];
        low_q[s+1]  <= {low_q[s][QB-2:0], qbit};
        den_q[s+1]  <= den_q[s];
        neg_q[s+1]  <= neg_q[s];
        dz_q[s+1]   <= dz_q[s];
        dpos_q[s+1] <= dpos_q[s];
        ovf_q[s+1]  <= ovf_q[s];
      end
    end
  end

  always_comb begin
    logic [QB-1:0] q;
    q = low_q[QB];
    if (dz_q[QB]) begin
      q_o = dpos_q[QB] ? Q_MAX : Q_MIN;
    end else if (ovf_q[QB]) begin
      q_o = neg_q[QB] ? Q_MIN : Q_MAX;
    end else if (neg_q[QB]) begin
      q_o = (q > QB'(Q_MIN)) ? Q_MIN : W'(~q + 1'b1);
    end else begin
      q_o = (q > QB'(Q_MAX)) ? Q_MAX : q[W-1:0];
    end
  end

endmodule

`default_nettype wire

@@ src/rbs_back.sv @@
// ----------------------------------------------------------------------------
// rbs_back: slab parameter pipeline and interval merge
// Six dividers in lockstep, then slab ordering, then the overlap test and
// the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module rbs_back (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire rbs_pkg::q_status_t q_st_i,
  input  wire rbs_pkg::job_t      job_i,
  output      logic               pop_o,
  output      logic               out_valid_o,
  input  wire logic               out_stall_i,
  output      logic               hit_o,
  output      logic [rbs_pkg::W-1:0] near_out_o,
  output      logic [rbs_pkg::W-1:0] far_out_o
);
  import rbs_pkg::*;

  logic         adv;
  logic         dv_q   [QB+1];
  logic [W-1:0] near_q [QB+2];
  logic [W-1:0] far_q  [QB+2];
  logic [W-1:0] tq     [NSLAB];
  logic         sv_q;
  logic [W-1:0] tlo_q  [NAXIS];
  logic [W-1:0] thi_q  [NAXIS];
  logic         ov_q;
  logic         hit_q;
  logic [W-1:0] nout_q, fout_q;
  logic         hit_d;
  logic [W-1:0] nout_d, fout_d;

  // Whole pipeline moves when the output register is free or taken
  assign adv   = !ov_q || !out_stall_i;
  assign pop_o = adv && !q_st_i.empty;

  for (genvar i = 0; i < NSLAB; i++) begin : g_div
    rbs_div u_div (
      .clk_i  (clk_i),
      .en_i   (adv),
      .num_i  (job_i.slab[i].num),
      .den_i  (job_i.axis[i % NAXIS].dmag),
      .neg_i  (job_i.slab[i].neg),
      .dz_i   (job_i.axis[i % NAXIS].dz),
      .dpos_i (job_i.slab[i].dpos),
      .q_o    (tq[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s <= QB; s++) dv_q[s] <= 1'b0;
      sv_q <= 1'b0;
      ov_q <= 1'b0;
    end else if (adv) begin
      dv_q[0] <= !q_st_i.empty;
      for (int s = 1; s <= QB; s++) dv_q[s] <= dv_q[s-1];
      sv_q <= dv_q[QB];
      ov_q <= sv_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      near_q[0] <= job_i.near_v;
      far_q[0]  <= job_i.far_v;
      for (int s = 1; s <= QB+1; s++) begin
        near_q[s] <= near_q[s-1];
        far_q[s]  <= far_q[s-1];
      end
      for (int a = 0; a < NAXIS; a++) begin
        if ($signed(tq[a]) > $signed(tq[a+NAXIS])) begin
          tlo_q[a] <= tq[a+NAXIS];
          thi_q[a] <= tq[a];
        end else begin
          tlo_q[a] <= tq[a];
          thi_q[a] <= tq[a+NAXIS];
        end
      end
      hit_q  <= hit_d;
      nout_q <= nout_d;
      fout_q <= fout_d;
    end
  end

  always_comb begin
    logic         ov_xy, ov_z;
    logic [W-1:0] m1, mx1, m2, mx2;
    ov_xy = !(($signed(tlo_q[0]) > $signed(thi_q[1])) ||
              ($signed(tlo_q[1]) > $signed(thi_q[0])));
    m1  = ($signed(tlo_q[1]) > $signed(tlo_q[0])) ? tlo_q[1] : tlo_q[0];
    mx1 = ($signed(thi_q[1]) < $signed(thi_q[0])) ? thi_q[1] : thi_q[0];
    ov_z = !(($signed(m1) > $signed(thi_q[2])) ||
             ($signed(tlo_q[2]) > $signed(mx1)));
    m2  = ($signed(tlo_q[2]) > $signed(m1))  ? tlo_q[2] : m1;
    mx2 = ($signed(thi_q[2]) < $signed(mx1)) ? thi_q[2] : mx1;
    hit_d  = ov_xy && ov_z;
    nout_d = (hit_d && ($signed(m2) < $signed(near_q[QB+1]))) ? m2 : near_q[QB+1];
    fout_d = (hit_d && ($signed(mx2) > $signed(far_q[QB+1]))) ? mx2 : far_q[QB+1];
  end

  assign out_valid_o = ov_q;
  assign hit_o       = hit_q;
  assign near_out_o  = nout_q;
  assign far_out_o   = fout_q;

endmodule

`default_nettype wire

@@ src/ray_box_slab_intersect_top.sv @@
// ----------------------------------------------------------------------------
// ray_box_slab_intersect_top: ray versus axis-aligned box slab test
// Signed fixed-point slab test against a box held in six registers; one
// result transfer for every ray transfer.
// ----------------------------------------------------------------------------
//
//   channel   handshake                   payload
//   -------   -------------------------   ----------------------------------
//   config    cfg_we_i                    cfg_idx_i, cfg_wdata_i
//   ray in    in_valid_i / in_stall_o     origin_*_i, dir_*_i, near/far_in_i
//   result    out_valid_o / out_stall_i   hit_o, near_out_o, far_out_o
//
// One ray per cycle is taken in steady state while the result side is not
// stalled. From a ray transfer to its result transfer the job passes the job
// queue, ending as the job loads the divider entry stage, then the
// bit-per-stage dividers, slab ordering and the merge into the output register.
// Reset clears the box registers, the queue and all valid bits.
// A stall on the result side freezes the back end; the two-entry queue
// absorbs the front end until it fills, then in_stall_o rises.
// ----------------------------------------------------------------------------
`default_nettype none

module ray_box_slab_intersect_top (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    cfg_we_i,
  input  wire logic [rbs_pkg::CIW-1:0] cfg_idx_i,
  input  wire logic [rbs_pkg::W-1:0]   cfg_wdata_i,
  input  wire logic                    in_valid_i,
  output      logic                    in_stall_o,
  input  wire logic [rbs_pkg::W-1:0]   origin_x_i,
  input  wire logic [rbs_pkg::W-1:0]   origin_y_i,
  input  wire logic [rbs_pkg::W-1:0]   origin_z_i,
  input  wire logic [rbs_pkg::W-1:0]   dir_x_i,
  input  wire logic [rbs_pkg::W-1:0]   dir_y_i,
  input  wire logic [rbs_pkg::W-1:0]   dir_z_i,
  input  wire logic [rbs_pkg::W-1:0]   near_in_i,
  input  wire logic [rbs_pkg::W-1:0]   far_in_i,
  output      logic                    out_valid_o,
  input  wire logic                    out_stall_i,
  output      logic                    hit_o,
  output      logic [rbs_pkg::W-1:0]   near_out_o,
  output      logic [rbs_pkg::W-1:0]   far_out_o
);
  import rbs_pkg::*;

  q_status_t q_st;
  job_t      push_job, head_job;
  logic      push, pop;

  // Front: box registers, classify each ray, push into the queue
  rbs_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .origin_x_i  (origin_x_i),
    .origin_y_i  (origin_y_i),
    .origin_z_i  (origin_z_i),
    .dir_x_i     (dir_x_i),
    .dir_y_i     (dir_y_i),
    .dir_z_i     (dir_z_i),
    .near_in_i   (near_in_i),
    .far_in_i    (far_in_i),
    .q_st_i      (q_st),
    .push_o      (push),
    .job_o       (push_job)
  );

  // Queue: lets the front keep taking rays while the back is held
  rbs_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .job_i  (push_job),
    .pop_i  (pop),
    .job_o  (head_job),
    .st_o   (q_st)
  );

  // Back: divide, order slabs, merge intervals, hold the result
  rbs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_st_i      (q_st),
    .job_i       (head_job),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .hit_o       (hit_o),
    .near_out_o  (near_out_o),
    .far_out_o   (far_out_o)
  );

  // A hit always leaves an ordered interval
  a_hit_ordered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && hit_o) |-> ($signed(near_out_o) <= $signed(far_out_o)))
    else $error("hit with near_out above far_out");

  // A ray transfer leaves a job in the queue on the next cycle
  a_push_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> !q_st.empty)
    else $error("accepted ray not held in queue");

  // The queue never reports full and empty together
  a_queue_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_st.full && q_st.empty))
    else $error("queue status inconsistent");

endmodule

`default_nettype wire
